@@ src/cci_pkg.sv @@
// Shared types and constants for the circle intersection pipeline and its checker.
package cci_pkg;

  // Width of one coordinate; radii are one bit narrower.
  localparam int unsigned CoordWidth = 32;

  // Point count codes
  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [CoordWidth-2:0]        radius_t;

  typedef struct packed {
    coord_t  centre1_x;
    coord_t  centre1_y;
    radius_t radius1;
    coord_t  centre2_x;
    coord_t  centre2_y;
    radius_t radius2;
  } cci_in_t;

  typedef struct packed {
    logic [1:0] point_count;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     second_x;
    coord_t     second_y;
  } cci_out_t;

endpackage

@@ src/circle_circle_intersection.sv @@
// Pipelined intersection of two circles in signed fixed point.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o | cci_in_t: two centres, two radii
//  out     | output    | out_valid_o/out_ready_i | cci_out_t: count and two points
//
// One word enters per cycle while the output is not stalled; the pipeline depth is set
// by the two root chains (one bit per stage) and the two long dividers (one
// quotient bit per stage, the second with four lanes side by side).
// Reset clears only the valid bits of the stages; data registers are not reset.
// A stall at the output freezes every stage at once, so no word is lost or repeated,
// and in_ready_o is high whenever the output register is empty or being taken.
module circle_circle_intersection import cci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cci_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cci_out_t out_data_o
);

  localparam int unsigned W     = CoordWidth;
  localparam int unsigned LW    = W + 1;          // centre distance bits
  localparam int unsigned LRW   = LW + 2;         // distance root remainder
  localparam int unsigned YW    = W;              // half chord bits
  localparam int unsigned YRW   = YW + 2;         // half chord root remainder
  localparam int unsigned NW    = 2 * W + 3;      // signed numerator width
  localparam int unsigned QW    = W;              // quotient bits
  localparam int unsigned DRW   = NW - QW;        // divider remainder width
  localparam int unsigned DEPTH = 14 + LW + 2 * QW + YW;

  typedef struct packed {
    logic                fail;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic [W-2:0]        r1;
    logic [W-2:0]        r2;
    logic [W-2:0]        rdiff;
    logic [W-1:0]        rsum;
    logic [2*W-3:0]      r1sq;
    logic [2*W-3:0]      r2sq;
    logic [LW-1:0]       len;
    logic signed [W:0]   xo;
    logic [YW-1:0]       yh;
  } ctx_t;

  logic adv;
  logic [DEPTH-1:0] vld_q;

  // Advance every stage together whenever the output register can move
  assign adv         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[DEPTH-1];

  // Shift the valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---------------- stage s1: differences ----------------
  ctx_t s1_c_d, s1_c_q;

  always_comb begin
    s1_c_d      = '0;
    s1_c_d.fail = (in_data_i.centre1_x == in_data_i.centre2_x) &&
                  (in_data_i.centre1_y == in_data_i.centre2_y);
    s1_c_d.x1   = in_data_i.centre1_x;
    s1_c_d.y1   = in_data_i.centre1_y;
    s1_c_d.dx   = (W+1)'(in_data_i.centre2_x) - (W+1)'(in_data_i.centre1_x);
    s1_c_d.dy   = (W+1)'(in_data_i.centre2_y) - (W+1)'(in_data_i.centre1_y);
    s1_c_d.r1   = in_data_i.radius1;
    s1_c_d.r2   = in_data_i.radius2;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_c_q <= s1_c_d;
    end
  end

  // ---------------- stage s2: squares, radius sum and difference ----------------
  ctx_t s2_c_d, s2_c_q;
  logic [2*W+1:0] s2_dxsq_d, s2_dysq_d, s2_dxsq_q, s2_dysq_q;

  always_comb begin
    s2_c_d       = s1_c_q;
    s2_c_d.rsum  = W'(s1_c_q.r1) + W'(s1_c_q.r2);
    s2_c_d.rdiff = (s1_c_q.r1 >= s1_c_q.r2) ? s1_c_q.r1 - s1_c_q.r2
                                            : s1_c_q.r2 - s1_c_q.r1;
    s2_c_d.r1sq  = s1_c_q.r1 * s1_c_q.r1;
    s2_c_d.r2sq  = s1_c_q.r2 * s1_c_q.r2;
    s2_dxsq_d    = s1_c_q.dx * s1_c_q.dx;
    s2_dysq_d    = s1_c_q.dy * s1_c_q.dy;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_c_q    <= s2_c_d;
      s2_dxsq_q <= s2_dxsq_d;
      s2_dysq_q <= s2_dysq_d;
    end
  end

  // ---------------- distance root: one result bit per stage ----------------
  ctx_t            ra_c_q    [LW+1];
  logic [2*LW-1:0] ra_rad_q  [LW+1];
  logic [LRW-1:0]  ra_rem_q  [LW+1];
  logic [LW-1:0]   ra_root_q [LW+1];

  // Load the sum of squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_c_q[0]    <= s2_c_q;
      ra_rad_q[0]  <= s2_dxsq_q + s2_dysq_q;
      ra_rem_q[0]  <= '0;
      ra_root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= LW; k++) begin : g_root_a
    logic [LRW-1:0] rem_sh, trial;

    assign rem_sh = {ra_rem_q[k-1][LRW-3:0], ra_rad_q[k-1][2*LW-1 -: 2]};
    assign trial  = {ra_root_q[k-1], 2'b01};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ra_c_q[k]   <= ra_c_q[k-1];
        ra_rad_q[k] <= ra_rad_q[k-1] << 2;
        if (rem_sh >= trial) begin
          ra_rem_q[k]  <= rem_sh - trial;
          ra_root_q[k] <= {ra_root_q[k-1][LW-2:0], 1'b1};
        end else begin
          ra_rem_q[k]  <= rem_sh;
          ra_root_q[k] <= {ra_root_q[k-1][LW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage p1: range check and distance square ----------------
  ctx_t p1_c_d, p1_c_q;
  logic [2*LW-1:0] p1_lensq_d, p1_lensq_q;

  always_comb begin
    p1_c_d      = ra_c_q[LW];
    p1_c_d.len  = ra_root_q[LW];
    p1_c_d.fail = ra_c_q[LW].fail ||
                  (ra_root_q[LW] > LW'(ra_c_q[LW].rsum)) ||
                  (ra_root_q[LW] < LW'(ra_c_q[LW].rdiff));
    p1_lensq_d  = ra_root_q[LW] * ra_root_q[LW];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_c_q     <= p1_c_d;
      p1_lensq_q <= p1_lensq_d;
    end
  end

  // ---------------- stage p2: chord offset numerator ----------------
  ctx_t p2_c_q;
  logic signed [NW-1:0] p2_num_d, p2_num_q;

  assign p2_num_d = $signed(NW'(p1_c_q.r1sq)) - $signed(NW'(p1_c_q.r2sq)) +
                    $signed(NW'(p1_lensq_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_c_q   <= p1_c_q;
      p2_num_q <= p2_num_d;
    end
  end

  // ---------------- chord offset divider: num / (2 * len) ----------------
  ctx_t           da_c_q   [QW+1];
  logic [DRW-1:0] da_rem_q [QW+1];
  logic [QW-1:0]  da_num_q [QW+1];
  logic [QW-1:0]  da_quo_q [QW+1];
  logic           da_neg_q [QW+1];
  logic [NW-1:0]  da_mag;

  assign da_mag = p2_num_q[NW-1] ? NW'(-p2_num_q) : NW'(p2_num_q);

  // Load the magnitude; the quotient stays below 2^QW, so the top part starts the remainder
  always_ff @(posedge clk_i) begin
    if (adv) begin
      da_c_q[0]   <= p2_c_q;
      da_rem_q[0] <= da_mag[NW-1:QW];
      da_num_q[0] <= da_mag[QW-1:0];
      da_quo_q[0] <= '0;
      da_neg_q[0] <= p2_num_q[NW-1];
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div_a
    logic [DRW-1:0] rem_sh, dvs;

    assign rem_sh = {da_rem_q[k-1][DRW-2:0], da_num_q[k-1][QW-1]};
    assign dvs    = DRW'({da_c_q[k-1].len, 1'b0});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        da_c_q[k]   <= da_c_q[k-1];
        da_num_q[k] <= da_num_q[k-1] << 1;
        da_neg_q[k] <= da_neg_q[k-1];
        if (rem_sh >= dvs) begin
          da_rem_q[k] <= rem_sh - dvs;
          da_quo_q[k] <= {da_quo_q[k-1][QW-2:0], 1'b1};
        end else begin
          da_rem_q[k] <= rem_sh;
          da_quo_q[k] <= {da_quo_q[k-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage h1: signed offset and its square ----------------
  ctx_t h1_c_d, h1_c_q;
  logic [2*QW-1:0] h1_xsq_d, h1_xsq_q;

  always_comb begin
    h1_c_d    = da_c_q[QW];
    h1_c_d.xo = da_neg_q[QW] ? -$signed({1'b0, da_quo_q[QW]})
                             : $signed({1'b0, da_quo_q[QW]});
    h1_xsq_d  = da_quo_q[QW] * da_quo_q[QW];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h1_c_q   <= h1_c_d;
      h1_xsq_q <= h1_xsq_d;
    end
  end

  // ---------------- half chord root ----------------
  ctx_t            rb_c_q    [YW+1];
  logic [2*YW-1:0] rb_rad_q  [YW+1];
  logic [YRW-1:0]  rb_rem_q  [YW+1];
  logic [YW-1:0]   rb_root_q [YW+1];
  logic signed [2*W:0] h2_diff;

  // Clamp a negative half chord square to zero
  assign h2_diff = $signed((2*W+1)'(h1_c_q.r1sq)) - $signed((2*W+1)'(h1_xsq_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rb_c_q[0]    <= h1_c_q;
      rb_rad_q[0]  <= h2_diff[2*W] ? '0 : h2_diff[2*W-1:0];
      rb_rem_q[0]  <= '0;
      rb_root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= YW; k++) begin : g_root_b
    logic [YRW-1:0] rem_sh, trial;

    assign rem_sh = {rb_rem_q[k-1][YRW-3:0], rb_rad_q[k-1][2*YW-1 -: 2]};
    assign trial  = {rb_root_q[k-1], 2'b01};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rb_c_q[k]   <= rb_c_q[k-1];
        rb_rad_q[k] <= rb_rad_q[k-1] << 2;
        if (rem_sh >= trial) begin
          rb_rem_q[k]  <= rem_sh - trial;
          rb_root_q[k] <= {rb_root_q[k-1][YW-2:0], 1'b1};
        end else begin
          rb_rem_q[k]  <= rem_sh;
          rb_root_q[k] <= {rb_root_q[k-1][YW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage m1: rotation products ----------------
  ctx_t m1_c_d, m1_c_q;
  logic signed [W:0]     m1_ys;
  logic signed [2*W+1:0] m1_prod_d [4];
  logic signed [2*W+1:0] m1_prod_q [4];

  always_comb begin
    m1_c_d       = rb_c_q[YW];
    m1_c_d.yh    = rb_root_q[YW];
    m1_ys        = $signed({1'b0, rb_root_q[YW]});
    m1_prod_d[0] = rb_c_q[YW].xo * rb_c_q[YW].dx;
    m1_prod_d[1] = m1_ys * rb_c_q[YW].dy;
    m1_prod_d[2] = rb_c_q[YW].xo * rb_c_q[YW].dy;
    m1_prod_d[3] = m1_ys * rb_c_q[YW].dx;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_c_q    <= m1_c_d;
      m1_prod_q <= m1_prod_d;
    end
  end

  // ---------------- stage m2: point numerators ----------------
  ctx_t m2_c_q;
  logic signed [NW-1:0] m2_sum_d [4];
  logic signed [NW-1:0] m2_sum_q [4];

  always_comb begin
    m2_sum_d[0] = NW'(m1_prod_q[0]) - NW'(m1_prod_q[1]);
    m2_sum_d[1] = NW'(m1_prod_q[2]) + NW'(m1_prod_q[3]);
    m2_sum_d[2] = NW'(m1_prod_q[0]) + NW'(m1_prod_q[1]);
    m2_sum_d[3] = NW'(m1_prod_q[2]) - NW'(m1_prod_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_c_q   <= m1_c_q;
      m2_sum_q <= m2_sum_d;
    end
  end

  // ---------------- point dividers: four lanes, num / len ----------------
  ctx_t           db_c_q   [QW+1];
  logic [DRW-1:0] db_rem_q [QW+1][4];
  logic [QW-1:0]  db_num_q [QW+1][4];
  logic [QW-1:0]  db_quo_q [QW+1][4];
  logic           db_neg_q [QW+1][4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      db_c_q[0] <= m2_c_q;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [NW-1:0] mag;

    assign mag = m2_sum_q[l][NW-1] ? NW'(-m2_sum_q[l]) : NW'(m2_sum_q[l]);

    // Load the lane magnitude
    always_ff @(posedge clk_i) begin
      if (adv) begin
        db_rem_q[0][l] <= mag[NW-1:QW];
        db_num_q[0][l] <= mag[QW-1:0];
        db_quo_q[0][l] <= '0;
        db_neg_q[0][l] <= m2_sum_q[l][NW-1];
      end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div_b
      logic [DRW-1:0] rem_sh, dvs;

      assign rem_sh = {db_rem_q[k-1][l][DRW-2:0], db_num_q[k-1][l][QW-1]};
      assign dvs    = DRW'(db_c_q[k-1].len);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          db_num_q[k][l] <= db_num_q[k-1][l] << 1;
          db_neg_q[k][l] <= db_neg_q[k-1][l];
          if (rem_sh >= dvs) begin
            db_rem_q[k][l] <= rem_sh - dvs;
            db_quo_q[k][l] <= {db_quo_q[k-1][l][QW-2:0], 1'b1};
          end else begin
            db_rem_q[k][l] <= rem_sh;
            db_quo_q[k][l] <= {db_quo_q[k-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_ctx_b
    always_ff @(posedge clk_i) begin
      if (adv) begin
        db_c_q[k] <= db_c_q[k-1];
      end
    end
  end

  // ---------------- stages f1, f2: sign and offset by the first centre ----------------
  ctx_t f1_c_q, f2_c_q;
  logic signed [W:0]   f1_sq_q [4];
  logic signed [W+1:0] f2_p_q  [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_c_q <= db_c_q[QW];
      f2_c_q <= f1_c_q;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_fin
    logic signed [W-1:0] base;

    assign base = (l % 2 == 0) ? f1_c_q.x1 : f1_c_q.y1;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        f1_sq_q[l] <= db_neg_q[QW][l] ? -$signed({1'b0, db_quo_q[QW][l]})
                                      : $signed({1'b0, db_quo_q[QW][l]});
        f2_p_q[l]  <= (W+2)'(base) + (W+2)'(f1_sq_q[l]);
      end
    end
  end

  // ---------------- output register: saturate, count, zero on failure ----------------
  cci_out_t out_d, out_q;

  function automatic logic [W-1:0] sat(input logic signed [W+1:0] v);
    logic [2:0] top;
    top = v[W+1:W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[W-1:0];
    end
    return v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  always_comb begin
    out_d = '0;
    if (!f2_c_q.fail) begin
      out_d.point_count = (f2_c_q.yh == '0) ? CountOne : CountTwo;
      out_d.first_x     = sat(f2_p_q[0]);
      out_d.first_y     = sat(f2_p_q[1]);
      out_d.second_x    = sat(f2_p_q[2]);
      out_d.second_y    = sat(f2_p_q[3]);
    end else begin
      out_d.point_count = CountNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ src/cci_checker.sv @@
// Port-level checker for the circle intersection pipeline, with its bind.
module cci_checker import cci_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cci_out_t out_data_o
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // Never block the input while the output register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Drop points when there is no intersection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.point_count == CountNone |->
      out_data_o.first_x == '0 && out_data_o.first_y == '0 &&
      out_data_o.second_x == '0 && out_data_o.second_y == '0)
    else $error("points not zero with no intersection");

  // A tangent gives one point twice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.point_count == CountOne |->
      out_data_o.first_x == out_data_o.second_x &&
      out_data_o.first_y == out_data_o.second_y)
    else $error("tangent points differ");

endmodule

bind circle_circle_intersection cci_checker u_cci_checker (.*);

@@ verif/circle_circle_intersection_tb.sv @@
// Testbench for the circle intersection pipeline: queued driver, checking monitor.
`timescale 1ns / 1ps

module circle_circle_intersection_tb;
  import cci_pkg::*;

  localparam int unsigned Latency    = 143;
  localparam int unsigned CycleLimit = 400000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  cci_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cci_out_t out_data_o;

  cci_in_t  pending_words[$];
  cci_out_t expected_points[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_phase = 0;
  bit          drain_hold = 1'b0;

  circle_circle_intersection i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Truncated square root of a nonnegative 128-bit value
  function automatic logic [63:0] root_trunc(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  // Truncate toward zero, d positive
  function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0) ? -((-n) / d) : n / d;
    return q;
  endfunction

  function automatic logic signed [127:0] clamp_to(logic signed [127:0] v, int bits);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic coord_t place_coord(logic signed [127:0] base,
                                         logic signed [127:0] num,
                                         logic signed [127:0] len);
    logic signed [127:0] p;
    p = clamp_to(base + div_trunc(num, len), CoordWidth);
    return coord_t'(p[CoordWidth-1:0]);
  endfunction

  // Predict the intersection points of one circle pair
  function automatic cci_out_t intersect_circles(cci_in_t w);
    cci_out_t o;
    logic signed [127:0] x1, y1, r1, r2, dx, dy, len, diff, num, x, y, h;
    o = '0;
    x1 = 128'(w.centre1_x);
    y1 = 128'(w.centre1_y);
    r1 = $signed({97'd0, w.radius1});
    r2 = $signed({97'd0, w.radius2});
    dx = 128'(w.centre2_x) - x1;
    dy = 128'(w.centre2_y) - y1;
    if (dx == 0 && dy == 0) return o;
    len = $signed({64'd0, root_trunc(dx * dx + dy * dy)});
    diff = (r2 > r1) ? r2 - r1 : r1 - r2;
    if (len > r1 + r2 || len < diff) return o;
    num = r1 * r1 - r2 * r2 + len * len;
    x = clamp_to(div_trunc(num, 2 * len), 62);
    h = r1 * r1 - x * x;
    y = (h < 0) ? 128'sd0 : $signed({64'd0, root_trunc(h)});
    o.point_count = (y == 0) ? CountOne : CountTwo;
    o.first_x  = place_coord(x1, x * dx - y * dy, len);
    o.first_y  = place_coord(y1, x * dy + y * dx, len);
    o.second_x = place_coord(x1, x * dx + y * dy, len);
    o.second_y = place_coord(y1, x * dy - y * dx, len);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic cci_in_t make_pair(coord_t ax, coord_t ay, radius_t ar,
                                        coord_t bx, coord_t by, radius_t br);
    cci_in_t w;
    w.centre1_x = ax; w.centre1_y = ay; w.radius1 = ar;
    w.centre2_x = bx; w.centre2_y = by; w.radius2 = br;
    return w;
  endfunction

  function automatic coord_t rand_coord(int unsigned span);
    coord_t c;
    case ($urandom_range(0, 3))
      0: c = coord_t'($urandom);
      default: c = coord_t'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endcase
    return c;
  endfunction

  // Drive words in bursts, holding a word until it is taken
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_points.push_back(intersect_circles(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() != 0 && !drain_hold && gap_left == 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
          end else if (burst_left == 1) begin
            burst_left <= 0;
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end
      end
      // Stall pattern: long open stretches, then choppy or blocked spans
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 64) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 2) != 0);
        2: out_ready_i <= (stall_phase % 7) < 3;
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Compare each taken word with the oldest prediction
  always @(posedge clk_i) begin
    cci_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_data_o.point_count), 64'd0);
      end else begin
        want = expected_points.pop_front();
        if (out_data_o.point_count != want.point_count)
          report_mismatch("point_count", 64'(out_data_o.point_count),
                          64'(want.point_count));
        if (out_data_o.first_x != want.first_x)
          report_mismatch("first_x", 64'(out_data_o.first_x), 64'(want.first_x));
        if (out_data_o.first_y != want.first_y)
          report_mismatch("first_y", 64'(out_data_o.first_y), 64'(want.first_y));
        if (out_data_o.second_x != want.second_x)
          report_mismatch("second_x", 64'(out_data_o.second_x), 64'(want.second_x));
        if (out_data_o.second_y != want.second_y)
          report_mismatch("second_y", 64'(out_data_o.second_y), 64'(want.second_y));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    coord_t  ax, ay, bx, by;
    radius_t ar, br;
    int unsigned span;
    int unsigned kind;
    coord_t  cmax, cmin;
    radius_t rmax;
    cmax = {1'b0, {(CoordWidth-1){1'b1}}};
    cmin = {1'b1, {(CoordWidth-1){1'b0}}};
    rmax = '1;

    // Directed: same centre, apart, nested, tangent, two points, extremes
    pending_words.push_back(make_pair(0, 0, 31'h10000, 0, 0, 31'h10000));
    pending_words.push_back(make_pair(0, 0, 31'h10000, 32'h100000, 0, 31'h10000));
    pending_words.push_back(make_pair(0, 0, 31'h100000, 32'h10000, 0, 31'h10000));
    pending_words.push_back(make_pair(0, 0, 31'h10000, 32'h20000, 0, 31'h10000));
    pending_words.push_back(make_pair(0, 0, 31'h30000, 32'h10000, 0, 31'h20000));
    pending_words.push_back(make_pair(0, 0, 31'h30000, 32'h30000, 32'h40000, 31'h40000));
    pending_words.push_back(make_pair(0, 0, 31'h20000, 32'h20000, 32'h20000, 31'h20000));
    pending_words.push_back(make_pair(-32'sh50000, 32'h10000, 31'h40000,
                                      32'h30000, -32'sh20000, 31'h50000));
    pending_words.push_back(make_pair(cmin, cmin, rmax, cmax, cmax, rmax));
    pending_words.push_back(make_pair(cmax, cmax, rmax, cmin, cmin, rmax));
    pending_words.push_back(make_pair(cmax, 0, rmax, cmax - 1, 0, rmax));
    pending_words.push_back(make_pair(cmin, 0, rmax, cmin + 1, 0, rmax));
    pending_words.push_back(make_pair(cmax, cmax, rmax, cmax - 32'h10000, cmax, rmax));
    pending_words.push_back(make_pair(0, 0, 31'd0, 1, 0, 31'd1));
    pending_words.push_back(make_pair(0, 0, 31'd0, 0, 1, 31'd0));
    pending_words.push_back(make_pair(0, 0, rmax, 1, 1, rmax));
    pending_words.push_back(make_pair(0, 0, 31'd3, 5, 0, 31'd3));
    pending_words.push_back(make_pair(0, 0, 31'd7, 10, 0, 31'd4));
    pending_words.push_back(make_pair(-1, -1, 31'd1, 1, 1, 31'd2));
    pending_words.push_back(make_pair(cmin, cmax, 31'd0, cmax, cmin, 31'd0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random: mostly nearby pairs with radii drawn from the same span as the offset
    for (int i = 0; i < 750; i++) begin
      kind = $urandom_range(0, 9);
      span = (kind < 2) ? 32'h7fffffff : $urandom_range(1, 32'h00ffffff);
      ax = rand_coord(span);
      ay = rand_coord(span);
      if (kind < 7) begin
        bx = ax + coord_t'($signed($urandom_range(0, 2 * span)) - $signed(span));
        by = ay + coord_t'($signed($urandom_range(0, 2 * span)) - $signed(span));
        ar = radius_t'($urandom_range(0, span));
        br = radius_t'($urandom_range(0, span));
      end else begin
        bx = rand_coord(span);
        by = rand_coord(span);
        ar = radius_t'($urandom);
        br = radius_t'($urandom);
      end
      if (kind == 9) begin
        bx = ax;
        by = ay;
      end
      pending_words.push_back(make_pair(ax, ay, ar, bx, by, br));
      // Once, part way through, hold the sender until the pipe has drained
      if (i == 300) begin
        wait (pending_words.size() <= 1);
        @(posedge clk_i);
        drain_hold <= 1'b1;
        wait (expected_points.size() == 0 && !in_valid_i);
        @(posedge clk_i);
        drain_hold <= 1'b0;
      end
    end

    wait (pending_words.size() == 0 && !in_valid_i);
    wait (expected_points.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
